### rtl/met_pkg.sv
// Shared constants, register codes and control types of the escape-time core.
package met_pkg;

  // Fixed-point format: signed, FRAC_BITS fraction bits, integer range [-8, 8)
  localparam int FRAC_BITS = 28;
  localparam int QW        = FRAC_BITS + 4;
  localparam int CFG_W     = 32;
  localparam int COUNT_W   = 20;
  localparam int FIELD_W   = 12;
  localparam int INDEX_W   = 3;

  localparam logic signed [63:0] Q_MAX  = (64'sd8 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [63:0] Q_MIN  = -(64'sd8 <<< FRAC_BITS);
  localparam logic signed [63:0] Q_FOUR = 64'sd4 <<< FRAC_BITS;

  localparam logic signed [CFG_W-1:0] X_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [CFG_W-1:0] Y_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [CFG_W-1:0] X_STEP_RST   = 32'sd262144;
  localparam logic signed [CFG_W-1:0] Y_STEP_RST   = 32'sd262144;
  localparam logic [COUNT_W-1:0]      MAX_ITER_RST = 20'd100000;

  typedef enum logic [INDEX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] x_origin;
    logic signed [CFG_W-1:0] y_origin;
    logic signed [CFG_W-1:0] x_step;
    logic signed [CFG_W-1:0] y_step;
    logic [COUNT_W-1:0]      max_iterations;
  } met_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch c, clear z and the count
    logic update;  // z = z*z + c
    logic square;  // square the new z components
    logic emit;    // load the result register
  } met_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic escape;    // |z|^2 > 4 after the latest update
    logic at_limit;  // update count has reached max_iterations
  } met_status_t;

endpackage

### rtl/met_channels.sv
// Valid/ready channel interfaces for pixel beats and result beats.
interface met_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [met_pkg::FIELD_W-1:0]   column;
  logic [met_pkg::FIELD_W-1:0]   row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface met_result_if;
  logic                          valid;
  logic                          ready;
  logic [met_pkg::COUNT_W-1:0]   iteration_count;
  logic                          escaped;

  modport source (output valid, output iteration_count, output escaped, input ready);
  modport sink (input valid, input iteration_count, input escaped, output ready);
endinterface

### rtl/met_config.sv
// Configuration register bank of the escape-time core.
module met_config (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [met_pkg::INDEX_W-1:0]   write_index,
  input  logic [met_pkg::CFG_W-1:0]     write_data,
  output met_pkg::met_cfg_t             cfg
);
  import met_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin       <= X_ORIGIN_RST;
      cfg.y_origin       <= Y_ORIGIN_RST;
      cfg.x_step         <= X_STEP_RST;
      cfg.y_step         <= Y_STEP_RST;
      cfg.max_iterations <= MAX_ITER_RST;
    end else if (write_enable) begin
      case (reg_index_t'(write_index))
        REG_X_ORIGIN: cfg.x_origin       <= signed'(write_data);
        REG_Y_ORIGIN: cfg.y_origin       <= signed'(write_data);
        REG_X_STEP:   cfg.x_step         <= signed'(write_data);
        REG_Y_STEP:   cfg.y_step         <= signed'(write_data);
        REG_MAX_ITER: cfg.max_iterations <= write_data[COUNT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

### rtl/met_ctrl.sv
// Sequencing state machine: accept, alternate update and square, emit.
module met_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  met_pkg::met_status_t  status,
  output met_pkg::met_cmd_t     cmd
);
  import met_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_SQUARE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;
  logic   out_free;

  assign finish   = status.escape || status.at_limit;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    cmd         = '0;
    pixel_ready = 1'b0;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (finish) begin
          // hold until the result register is free
          if (out_free) begin
            cmd.emit   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.update = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_UPDATE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/met_datapath.sv
// Fixed-point datapath: c generation, z update, squares, escape test, result.
module met_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  met_pkg::met_cmd_t             cmd,
  input  met_pkg::met_cfg_t             cfg,
  input  logic [met_pkg::FIELD_W-1:0]   column,
  input  logic [met_pkg::FIELD_W-1:0]   row,
  output met_pkg::met_status_t          status,
  output logic [met_pkg::COUNT_W-1:0]   iteration_count,
  output logic                          escaped
);
  import met_pkg::*;

  localparam logic [FIELD_W-1:0] COORD_MASK =
    (COORD_BITS >= FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'((1 << COORD_BITS) - 1);

  function automatic logic signed [QW-1:0] sat_q(input logic signed [63:0] v);
    logic signed [QW-1:0] r;
    if (v > Q_MAX) begin
      r = QW'(Q_MAX);
    end else if (v < Q_MIN) begin
      r = QW'(Q_MIN);
    end else begin
      r = QW'(v);
    end
    return r;
  endfunction

  // Product floored to FRAC_BITS fraction bits, then saturated
  function automatic logic signed [QW-1:0] mul_q(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return sat_q(64'(p >>> FRAC_BITS));
  endfunction

  logic signed [QW-1:0]        cr, ci, zr, zi, zr2, zi2;
  logic [COUNT_W-1:0]          iter;

  logic [FIELD_W-1:0]          col_m, row_m;
  logic signed [CFG_W+FIELD_W:0] xprod, yprod;
  logic signed [QW-1:0]        cr_next, ci_next;
  logic signed [QW-1:0]        cross_term, nr, ni, sq_r, sq_i;
  logic signed [QW:0]          mag;

  assign col_m   = column & COORD_MASK;
  assign row_m   = row & COORD_MASK;
  assign xprod   = cfg.x_step * $signed({1'b0, col_m});
  assign yprod   = cfg.y_step * $signed({1'b0, row_m});
  assign cr_next = sat_q(64'(cfg.x_origin) + 64'(xprod));
  assign ci_next = sat_q(64'(cfg.y_origin) + 64'(yprod));

  assign cross_term = mul_q(zr, zi);
  assign nr         = sat_q(64'(zr2) - 64'(zi2) + 64'(cr));
  assign ni         = sat_q((64'(cross_term) <<< 1) + 64'(ci));
  assign sq_r       = mul_q(zr, zr);
  assign sq_i       = mul_q(zi, zi);

  // both squares are non-negative
  assign mag             = (QW+1)'(zr2) + (QW+1)'(zi2);
  assign status.escape   = mag > (QW+1)'(Q_FOUR);
  assign status.at_limit = iter == cfg.max_iterations;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cr   <= cr_next;
      ci   <= ci_next;
      zr   <= '0;
      zi   <= '0;
      zr2  <= '0;
      zi2  <= '0;
      iter <= '0;
    end
    if (cmd.update) begin
      zr   <= nr;
      zi   <= ni;
      iter <= iter + COUNT_W'(1);
    end
    if (cmd.square) begin
      zr2 <= sq_r;
      zi2 <= sq_i;
    end
    if (cmd.emit) begin
      // the escaping update itself does not count
      iteration_count <= status.escape ? iter - COUNT_W'(1) : iter;
      escaped         <= status.escape;
    end
  end

endmodule

### rtl/mandelbrot_escape_time_core.sv
// Top level of the escape-time core: config bank, controller and datapath.
//
// Usage: each beat on the pixel channel carries a column and a row. The core
// forms c = (x_origin + x_step*column, y_origin + y_step*row) in signed Q4.28,
// iterates z = z*z + c from z = 0 and returns one beat on the result channel:
// the number of updates completed before |z|^2 exceeded 4 (or max_iterations)
// and an escaped flag. Configuration goes through the plain write port
// (write_enable, write_index, write_data); write only while the core is idle.
//
// Timing: c is formed in the accept cycle. Each iteration is an update step
// (cross product and sums) followed by a square step for the two squares,
// and the escape test runs alongside the following update. The recurrence
// through the shared update/square datapath keeps one pixel in flight: the
// next pixel is taken only once the current one has been emitted.
//
// Reset clears the controller and loads the register defaults. A result
// waits in the output register while the receiver stalls; the next pixel can
// be accepted meanwhile, but its result holds in the datapath until the
// output register frees up.
module mandelbrot_escape_time_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [met_pkg::INDEX_W-1:0]   write_index,
  input  logic [met_pkg::CFG_W-1:0]     write_data,
  met_pixel_if.sink                     pixel,
  met_result_if.source                  result
);
  import met_pkg::*;

  met_cfg_t    cfg;
  met_cmd_t    cmd;
  met_status_t status;

  // register bank
  met_config u_config (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  // sequencing and both handshakes
  met_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic and the result payload register
  met_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .cfg             (cfg),
    .column          (pixel.column),
    .row             (pixel.row),
    .status          (status),
    .iteration_count (result.iteration_count),
    .escaped         (result.escaped)
  );

endmodule
